// ===== rtl/lr_pkg.sv =====
// Shared types and constants for the linear resampler.
`default_nettype none

package lr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int MAX_BURST_DEF   = 64;

    // Register index on the configuration port (byte address / 4)
    typedef enum logic {
        REG_SRC_LEN = 1'b0,
        REG_DST_LEN = 1'b1
    } lr_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_LERP_GO,
        ST_LERP_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_EMIT_COPY,
        ST_FINISH,
        ST_READ,
        ST_SHOW
    } lr_state_t;

endpackage

`default_nettype wire

// ===== rtl/lr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module lr_div #(
    parameter int DIVIDEND_BITS = 32,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic      [DIVIDEND_BITS-1:0] quotient,
    output logic      [DIVISOR_BITS-1:0]  remainder,
    output logic                          done
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // rem stays below the divisor, so trial - divisor fits the divisor width
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(DIVIDEND_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ===== rtl/lr_buf.sv =====
// Burst result buffer: one write port, one registered read port.
`default_nettype none

module lr_buf #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_resampler.sv =====
// Linear resampler top: sequencer, datapath and configuration registers.
// Each computed output takes two passes of the shared one-bit-per-cycle divider; a repeated
// sample is copied through the check and copy states instead. Each input also passes a check
// and a finish state; results are buffered per input and then drained one beat at a time
// (read, then show), so the next input is taken only after the whole burst.
// Reset (asynchronous, active low) sets src_len and dst_len to 1 and clears all counters.
`default_nettype none

module linear_resampler #(
    parameter int SAMPLE_BITS = lr_pkg::SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS = lr_pkg::LENGTH_BITS_DEF,
    parameter int MAX_BURST   = lr_pkg::MAX_BURST_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // sample channel
    input  wire logic                   sample_valid,
    output logic                        sample_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic      [SAMPLE_BITS-1:0] value,
    output logic                        burst_last,
    output logic                        record_done,
    output logic                        burst_overflow,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int LB = LENGTH_BITS;
    localparam int DW = SAMPLE_BITS + LENGTH_BITS;
    localparam int CW = $clog2(MAX_BURST + 1);
    localparam int AW = $clog2(MAX_BURST);
    localparam logic [SB-1:0] SIGN_FLIP = {1'b1, {(SB-1){1'b0}}};
    localparam logic [LB-1:0] LEN_MAX   = {LB{1'b1}};

    lr_pkg::lr_state_t state_reg, state_next;

    logic [LB-1:0] src_len_reg, dst_len_reg;
    logic [SB-1:0] prev_reg, cur_reg, val_reg;
    logic [LB-1:0] in_idx_reg, out_idx_reg, left_idx_reg, frac_reg;
    logic [DW-1:0] prod_reg;
    logic          down_reg;
    logic [CW-1:0] n_reg, rd_ptr_reg;
    logic          ovf_reg, reached_reg;

    // control from the output decoder
    logic sample_take, result_take;
    logic div_start, div_step_sel, emit, lerp_done, buf_rd_en;

    // derived values
    logic [LB-1:0] s_eff, d_eff, den, stepv;
    logic          special, final_item, more;
    logic [SB-1:0] prev_off, cur_off, diff_abs;
    logic          cur_up;
    logic [LB:0]   sum;
    logic [DW-1:0] div_dividend, div_quo;
    logic [LB-1:0] div_rem;
    logic          div_done;
    logic [LB:0]   twice_rem;
    logic          rnd;
    logic [SB:0]   qq, lerp_res;
    logic [SB-1:0] lerp_val;
    logic [LB+1:0] nl;
    logic [SB-1:0] wr_val;
    logic          buf_wr_en;
    logic [SB-1:0] buf_rd_data;
    logic          last_beat;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_len_reg <= LB'(1);
            dst_len_reg <= LB'(1);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (lr_pkg::lr_reg_t'(paddr[2]))
                lr_pkg::REG_SRC_LEN: src_len_reg <= pwdata[LB-1:0];
                lr_pkg::REG_DST_LEN: dst_len_reg <= pwdata[LB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (lr_pkg::lr_reg_t'(paddr[2]))
            lr_pkg::REG_SRC_LEN: prdata = 32'(src_len_reg);
            lr_pkg::REG_DST_LEN: prdata = 32'(dst_len_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- derived control values ----------------
    always_comb
    begin
        s_eff      = (src_len_reg == '0) ? LB'(1) : src_len_reg;
        d_eff      = (dst_len_reg == '0) ? LB'(1) : dst_len_reg;
        den        = d_eff - LB'(1);
        stepv      = s_eff - LB'(1);
        special    = (s_eff == LB'(1)) || (d_eff == LB'(1));
        final_item = ({1'b0, in_idx_reg} + (LB+1)'(1)) >= {1'b0, s_eff};
        if (special)
        begin
            more = (in_idx_reg == '0) && (out_idx_reg < d_eff);
        end
        else
        begin
            more = (in_idx_reg != '0) && (out_idx_reg < d_eff)
                   && (final_item || (left_idx_reg < in_idx_reg));
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lr_pkg::ST_IDLE:
                if (sample_take)
                begin
                    state_next = lr_pkg::ST_CHECK;
                end
            lr_pkg::ST_CHECK:
                if (!more)
                begin
                    state_next = lr_pkg::ST_FINISH;
                end
                else if (special)
                begin
                    state_next = lr_pkg::ST_EMIT_COPY;
                end
                else
                begin
                    state_next = lr_pkg::ST_MUL;
                end
            lr_pkg::ST_MUL:       state_next = lr_pkg::ST_LERP_GO;
            lr_pkg::ST_LERP_GO:   state_next = lr_pkg::ST_LERP_WAIT;
            lr_pkg::ST_LERP_WAIT:
                if (div_done)
                begin
                    state_next = lr_pkg::ST_STEP_GO;
                end
            lr_pkg::ST_STEP_GO:   state_next = lr_pkg::ST_STEP_WAIT;
            lr_pkg::ST_STEP_WAIT:
                if (div_done)
                begin
                    state_next = lr_pkg::ST_CHECK;
                end
            lr_pkg::ST_EMIT_COPY: state_next = lr_pkg::ST_CHECK;
            lr_pkg::ST_FINISH:
                state_next = (n_reg == '0) ? lr_pkg::ST_IDLE : lr_pkg::ST_READ;
            lr_pkg::ST_READ:      state_next = lr_pkg::ST_SHOW;
            lr_pkg::ST_SHOW:
                if (result_take)
                begin
                    state_next = last_beat ? lr_pkg::ST_IDLE : lr_pkg::ST_READ;
                end
            default:              state_next = lr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall = (state_reg != lr_pkg::ST_IDLE);
        result_valid = (state_reg == lr_pkg::ST_SHOW);
        div_start    = (state_reg == lr_pkg::ST_LERP_GO) || (state_reg == lr_pkg::ST_STEP_GO);
        div_step_sel = (state_reg == lr_pkg::ST_STEP_GO);
        lerp_done    = (state_reg == lr_pkg::ST_LERP_WAIT) && div_done;
        emit         = ((state_reg == lr_pkg::ST_STEP_WAIT) && div_done)
                       || (state_reg == lr_pkg::ST_EMIT_COPY);
        buf_rd_en    = (state_reg == lr_pkg::ST_READ);
    end

    assign sample_take = sample_valid && !sample_stall;
    assign result_take = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- arithmetic ----------------
    always_comb
    begin
        prev_off = prev_reg ^ SIGN_FLIP;
        cur_off  = cur_reg ^ SIGN_FLIP;
        cur_up   = (cur_off >= prev_off);
        diff_abs = cur_up ? (cur_off - prev_off) : (prev_off - cur_off);
        sum      = {1'b0, frac_reg} + {1'b0, stepv};
        div_dividend = div_step_sel ? DW'(sum) : prod_reg;
    end

    lr_div #(
        .DIVIDEND_BITS (DW),
        .DIVISOR_BITS  (LB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (den),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // round half up in offset binary: ties go up when rising, stay when falling
    always_comb
    begin
        twice_rem = {div_rem, 1'b0};
        rnd       = down_reg ? (twice_rem > {1'b0, den}) : (twice_rem >= {1'b0, den});
        qq        = {1'b0, div_quo[SB-1:0]} + (SB+1)'(rnd);
        lerp_res  = down_reg ? ({1'b0, prev_off} - qq) : ({1'b0, prev_off} + qq);
        lerp_val  = (left_idx_reg < in_idx_reg) ? (lerp_res[SB-1:0] ^ SIGN_FLIP) : cur_reg;
        nl        = (LB+2)'(left_idx_reg) + (LB+2)'(div_quo[LB:0]);
    end

    // ---------------- burst buffer ----------------
    assign wr_val    = (state_reg == lr_pkg::ST_EMIT_COPY) ? cur_reg : val_reg;
    assign buf_wr_en = emit && (n_reg < CW'(MAX_BURST));
    assign last_beat = ((rd_ptr_reg + CW'(1)) == n_reg);

    lr_buf #(
        .WIDTH (SB),
        .DEPTH (MAX_BURST)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (n_reg[AW-1:0]),
        .wr_data (wr_val),
        .rd_en   (buf_rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (buf_rd_data)
    );

    assign value          = buf_rd_data;
    assign burst_last     = last_beat;
    assign record_done    = reached_reg && last_beat;
    assign burst_overflow = ovf_reg;

    // ---------------- state and counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            in_idx_reg   <= '0;
            out_idx_reg  <= '0;
            left_idx_reg <= '0;
            frac_reg     <= '0;
            n_reg        <= '0;
            rd_ptr_reg   <= '0;
            ovf_reg      <= 1'b0;
            reached_reg  <= 1'b0;
        end
        else
        begin
            if (sample_take)
            begin
                n_reg       <= '0;
                ovf_reg     <= 1'b0;
                reached_reg <= 1'b0;
            end
            if (emit)
            begin
                // past the buffer depth, drop the result and flag the overflow; the output index still advances
                if (n_reg < CW'(MAX_BURST))
                begin
                    n_reg <= n_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                out_idx_reg <= out_idx_reg + LB'(1);
                if (({1'b0, out_idx_reg} + (LB+1)'(1)) >= {1'b0, d_eff})
                begin
                    reached_reg <= 1'b1;
                end
            end
            if ((state_reg == lr_pkg::ST_STEP_WAIT) && div_done)
            begin
                left_idx_reg <= (nl[LB+1:LB] != 2'b00) ? LEN_MAX : nl[LB-1:0];
                frac_reg     <= div_rem;
            end
            if (state_reg == lr_pkg::ST_FINISH)
            begin
                prev_reg   <= cur_reg;
                rd_ptr_reg <= '0;
                if (final_item)
                begin
                    in_idx_reg   <= '0;
                    out_idx_reg  <= '0;
                    left_idx_reg <= '0;
                    frac_reg     <= '0;
                end
                else
                begin
                    in_idx_reg <= in_idx_reg + LB'(1);
                end
            end
            if ((state_reg == lr_pkg::ST_SHOW) && result_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            cur_reg <= sample;
        end
        if (state_reg == lr_pkg::ST_MUL)
        begin
            prod_reg <= DW'(diff_abs) * DW'(frac_reg);
            down_reg <= !cur_up;
        end
        if (lerp_done)
        begin
            val_reg <= lerp_val;
        end
    end

    // ---------------- assertions ----------------
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_BURST))
        else $error("burst count past buffer depth");

    a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (n_reg != '0) && (rd_ptr_reg < n_reg))
        else $error("result shown from an empty or exhausted burst");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_take && burst_last) |=> (state_reg == lr_pkg::ST_IDLE))
        else $error("block not idle after the last beat of a burst");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lr_pkg::ST_LERP_WAIT)
                     || (state_reg == lr_pkg::ST_STEP_WAIT))
        else $error("divider finished with nobody waiting");

endmodule

`default_nettype wire
